FILE: rtl/ntc_pkg.sv
// Shared types, constants and the log2 table for the NTC thermistor block.
// Used by ntc_thermistor_temperature and its checker; no dependencies.
package ntc_pkg;

  localparam int ADC_WIDTH      = 16;
  localparam int LOG_TABLE_SIZE = 256;
  localparam int LOG_IDX_W      = $clog2(LOG_TABLE_SIZE);
  localparam int LOG_FRAC_W     = 31 - LOG_IDX_W;
  localparam int DIV_W          = 54;

  localparam logic [29:0] LN2_Q30             = 30'd744261118;
  localparam int          KELVIN_OFFSET_CENTI = 27315;
  localparam int          TEMP_MAX            = 32767;

  // Register reset values
  localparam logic [22:0] VREF_RST   = 23'd3300000;
  localparam logic [16:0] FS_RST     = 17'd4096;
  localparam logic [19:0] OFFS_RST   = 20'd0;
  localparam logic [16:0] WEIGHT_RST = 17'd6554;
  localparam logic [19:0] SERIES_RST = 20'd10000;
  localparam logic [19:0] NOM_RST    = 20'd50000;
  localparam logic [13:0] BETA_RST   = 14'd3950;
  localparam logic [15:0] TREF_RST   = 16'd29815;

  typedef enum logic [2:0] {
    CFG_VREF, CFG_FULL_SCALE, CFG_OFFSET, CFG_WEIGHT,
    CFG_SERIES, CFG_NOMINAL, CFG_BETA, CFG_TREF
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_SV, S_DL_SV, S_DIV_SV, S_MUL_NEW, S_MUL_OLD, S_FILT, S_CHK,
    S_DL_R, S_DIV_R, S_RSAT, S_NORM, S_LOGM, S_LOGA, S_MUL_LN, S_LN, S_MUL_TL,
    S_D, S_MUL_TB, S_NLOAD, S_DIV_T, S_TEMP, S_DONE
  } state_t;

  typedef logic [16:0] log_tab_t [0:LOG_TABLE_SIZE];

  // log2(1 + i/size) in Q16 by repeated squaring in Q30, rounded half up
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [31:0] r;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      y = (64'(LOG_TABLE_SIZE + i) << 30) / LOG_TABLE_SIZE;
      r = 32'd0;
      for (int k = 0; k < 17; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r = r | 32'd1;
        end
      end
      t[i] = 17'((r + 32'd1) >> 1);
    end
    t[LOG_TABLE_SIZE] = 17'd65536;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: rtl/ntc_thermistor_temperature.sv
// One item at a time: no new sample is accepted until the last result has been taken.
// The full path makes three passes of the shared radix-2 divider and runs the two
// normalize loops; one multiplier.
// Synchronous active-high reset restores register defaults and clears the filter.
// Depends on ntc_pkg.
module ntc_thermistor_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] filtered_microvolts,
  output logic [31:0]        resistance_ohms,
  output logic signed [15:0] temperature_centi_c,
  output logic               status
);

  ntc_pkg::state_t state, state_next;

  // configuration registers
  logic [22:0]        vref;
  logic [16:0]        fs;
  logic signed [19:0] offs;
  logic [16:0]        weight;
  logic [19:0]        series;
  logic [19:0]        nominal;
  logic [13:0]        beta;
  logic [15:0]        tref;

  // datapath registers
  logic signed [23:0] fm;
  logic [15:0]        samp;
  logic signed [65:0] prod;
  logic signed [59:0] acc;
  logic [53:0]        num;
  logic [38:0]        rem;
  logic [38:0]        dvs;
  logic [5:0]         cnt;
  logic [31:0]        r_out;
  logic [31:0]        nx;
  logic [4:0]         e;
  logic               log_sel;
  logic [16:0]        tab_a;
  logic signed [22:0] l2;
  logic signed [21:0] ln;
  logic signed [39:0] d;
  logic signed [15:0] temp;
  logic               stat;

  // shared multiplier operands
  logic signed [41:0] mul_a;
  logic signed [23:0] mul_b;

  // combinational helpers
  logic [16:0]        fs_eff, a_eff, a_inv;
  logic [19:0]        nom_eff;
  logic signed [40:0] v;
  logic signed [59:0] fsum;
  logic signed [43:0] f_full;
  logic signed [23:0] f_sat;
  logic               chk_low, chk_high;
  logic [39:0]        rem_sh, rem_sub;
  logic               div_ge, div_last;
  logic [31:0]        r_sat;
  logic [ntc_pkg::LOG_IDX_W-1:0]  idx;
  logic [ntc_pkg::LOG_FRAC_W-1:0] frac;
  logic [16:0]        tab_lo, tab_hi;
  logic [21:0]        lg;
  logic signed [65:0] ln_full;
  logic [20:0]        beta100;
  logic signed [39:0] d_calc;
  logic [36:0]        tb100;
  logic [53:0]        n_div;

  assign fs_eff  = (fs == 17'd0) ? 17'd1 : fs;
  assign nom_eff = (nominal == 20'd0) ? 20'd1 : nominal;
  assign a_eff   = (weight > 17'd65536) ? 17'd65536 : weight;
  assign a_inv   = 17'(18'd65536 - {1'b0, a_eff});

  // voltage after conversion and offset
  assign v = $signed({2'b00, num[38:0]}) - {{21{offs[19]}}, offs};

  // filter sum, floor shift and saturation
  assign fsum   = acc + prod[59:0];
  assign f_full = 44'(fsum >>> 16);
  always_comb begin
    if (f_full > 44'sd8388607) begin
      f_sat = 24'sh7FFFFF;
    end else if (f_full < -44'sd8388608) begin
      f_sat = 24'sh800000;
    end else begin
      f_sat = f_full[23:0];
    end
  end

  assign chk_low  = fm[23] || (fm == 24'sd0);
  assign chk_high = fm > $signed({1'b0, vref});

  // restoring divider step
  assign rem_sh   = {rem, num[53]};
  assign div_ge   = rem_sh >= {1'b0, dvs};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign div_last = (cnt == 6'(ntc_pkg::DIV_W - 1));

  assign r_sat = (num[53:32] != 22'd0) ? 32'hFFFFFFFF : num[31:0];

  // table lookup for the normalized mantissa
  assign idx    = nx[30 -: ntc_pkg::LOG_IDX_W];
  assign frac   = nx[ntc_pkg::LOG_FRAC_W-1:0];
  assign tab_lo = ntc_pkg::LOG_TAB[{1'b0, idx}];
  assign tab_hi = ntc_pkg::LOG_TAB[{1'b0, idx} + (ntc_pkg::LOG_IDX_W+1)'(1)];
  assign lg     = 22'({e, 16'd0}) + 22'(tab_a) + 22'(prod[39:23]);

  assign ln_full = (prod + 66'sd536870912) >>> 30;

  assign beta100 = 21'({beta, 6'd0}) + 21'({beta, 5'd0}) + 21'({beta, 2'd0});
  assign d_calc  = $signed({3'b000, beta100, 16'd0}) + prod[39:0];
  assign tb100   = 37'({prod[29:0], 6'd0}) + 37'({prod[29:0], 5'd0})
                 + 37'({prod[29:0], 2'd0});
  assign n_div   = 54'({tb100, 16'd0}) + 54'(d[38:1]);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ntc_pkg::S_MUL_SV: begin
        mul_a = 42'(vref);
        mul_b = 24'(samp);
      end
      ntc_pkg::S_MUL_NEW: begin
        mul_a = {v[40], v};
        mul_b = 24'(a_eff);
      end
      ntc_pkg::S_MUL_OLD: begin
        mul_a = {{18{fm[23]}}, fm};
        mul_b = 24'(a_inv);
      end
      ntc_pkg::S_CHK: begin
        mul_a = 42'(vref - fm[22:0]);
        mul_b = 24'(series);
      end
      ntc_pkg::S_LOGM: begin
        mul_a = 42'(tab_hi - tab_lo);
        mul_b = 24'(frac);
      end
      ntc_pkg::S_MUL_LN: begin
        mul_a = 42'(ntc_pkg::LN2_Q30);
        mul_b = {l2[22], l2};
      end
      ntc_pkg::S_MUL_TL: begin
        mul_a = {{20{ln[21]}}, ln};
        mul_b = 24'(tref);
      end
      ntc_pkg::S_MUL_TB: begin
        mul_a = 42'(tref);
        mul_b = 24'(beta);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ntc_pkg::S_IDLE:    if (in_valid) state_next = ntc_pkg::S_MUL_SV;
      ntc_pkg::S_MUL_SV:  state_next = ntc_pkg::S_DL_SV;
      ntc_pkg::S_DL_SV:   state_next = ntc_pkg::S_DIV_SV;
      ntc_pkg::S_DIV_SV:  if (div_last) state_next = ntc_pkg::S_MUL_NEW;
      ntc_pkg::S_MUL_NEW: state_next = ntc_pkg::S_MUL_OLD;
      ntc_pkg::S_MUL_OLD: state_next = ntc_pkg::S_FILT;
      ntc_pkg::S_FILT:    state_next = ntc_pkg::S_CHK;
      ntc_pkg::S_CHK: begin
        if (chk_low || chk_high) state_next = ntc_pkg::S_DONE;
        else state_next = ntc_pkg::S_DL_R;
      end
      ntc_pkg::S_DL_R:    state_next = ntc_pkg::S_DIV_R;
      ntc_pkg::S_DIV_R:   if (div_last) state_next = ntc_pkg::S_RSAT;
      ntc_pkg::S_RSAT: begin
        if (r_sat == 32'd0) state_next = ntc_pkg::S_DONE;
        else state_next = ntc_pkg::S_NORM;
      end
      ntc_pkg::S_NORM:    if (nx[31]) state_next = ntc_pkg::S_LOGM;
      ntc_pkg::S_LOGM:    state_next = ntc_pkg::S_LOGA;
      ntc_pkg::S_LOGA: begin
        if (log_sel) state_next = ntc_pkg::S_MUL_LN;
        else state_next = ntc_pkg::S_NORM;
      end
      ntc_pkg::S_MUL_LN:  state_next = ntc_pkg::S_LN;
      ntc_pkg::S_LN:      state_next = ntc_pkg::S_MUL_TL;
      ntc_pkg::S_MUL_TL:  state_next = ntc_pkg::S_D;
      ntc_pkg::S_D: begin
        if (d_calc <= 40'sd0) state_next = ntc_pkg::S_DONE;
        else state_next = ntc_pkg::S_MUL_TB;
      end
      ntc_pkg::S_MUL_TB:  state_next = ntc_pkg::S_NLOAD;
      ntc_pkg::S_NLOAD:   state_next = ntc_pkg::S_DIV_T;
      ntc_pkg::S_DIV_T:   if (div_last) state_next = ntc_pkg::S_TEMP;
      ntc_pkg::S_TEMP:    state_next = ntc_pkg::S_DONE;
      ntc_pkg::S_DONE:    if (!out_stall) state_next = ntc_pkg::S_IDLE;
      default:            state_next = ntc_pkg::S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vref    <= ntc_pkg::VREF_RST;
      fs      <= ntc_pkg::FS_RST;
      offs    <= ntc_pkg::OFFS_RST;
      weight  <= ntc_pkg::WEIGHT_RST;
      series  <= ntc_pkg::SERIES_RST;
      nominal <= ntc_pkg::NOM_RST;
      beta    <= ntc_pkg::BETA_RST;
      tref    <= ntc_pkg::TREF_RST;
    end else if (cfg_wen) begin
      unique case (ntc_pkg::cfg_idx_t'(cfg_index))
        ntc_pkg::CFG_VREF:       vref    <= cfg_data;
        ntc_pkg::CFG_FULL_SCALE: fs      <= cfg_data[16:0];
        ntc_pkg::CFG_OFFSET:     offs    <= cfg_data[19:0];
        ntc_pkg::CFG_WEIGHT:     weight  <= cfg_data[16:0];
        ntc_pkg::CFG_SERIES:     series  <= cfg_data[19:0];
        ntc_pkg::CFG_NOMINAL:    nominal <= cfg_data[19:0];
        ntc_pkg::CFG_BETA:       beta    <= cfg_data[13:0];
        ntc_pkg::CFG_TREF:       tref    <= cfg_data[15:0];
        default:                 vref    <= vref;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      fm <= 24'sd0;
    end else if (state == ntc_pkg::S_FILT) begin
      fm <= f_sat;
    end
  end

  // shared multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ntc_pkg::S_IDLE: begin
        samp <= 16'(adc_sample[ntc_pkg::ADC_WIDTH-1:0]);
        stat <= 1'b0;
      end
      ntc_pkg::S_DL_SV: begin
        num <= 54'(prod[38:0]);
        dvs <= 39'(fs_eff);
        rem <= '0;
        cnt <= '0;
      end
      ntc_pkg::S_DIV_SV, ntc_pkg::S_DIV_R, ntc_pkg::S_DIV_T: begin
        rem <= div_ge ? rem_sub[38:0] : rem_sh[38:0];
        num <= {num[52:0], div_ge};
        cnt <= cnt + 6'd1;
      end
      ntc_pkg::S_MUL_OLD: acc <= prod[59:0];
      ntc_pkg::S_CHK: begin
        if (chk_low) begin
          stat  <= 1'b1;
          r_out <= 32'hFFFFFFFF;
          temp  <= 16'(-ntc_pkg::KELVIN_OFFSET_CENTI);
        end else if (chk_high) begin
          stat  <= 1'b1;
          r_out <= 32'd0;
          temp  <= 16'(ntc_pkg::TEMP_MAX);
        end
      end
      ntc_pkg::S_DL_R: begin
        num <= 54'(prod[42:0]);
        dvs <= 39'(fm[22:0]);
        rem <= '0;
        cnt <= '0;
      end
      ntc_pkg::S_RSAT: begin
        r_out   <= r_sat;
        temp    <= 16'(ntc_pkg::TEMP_MAX);
        nx      <= r_sat;
        e       <= 5'd31;
        log_sel <= 1'b0;
      end
      ntc_pkg::S_NORM: begin
        if (!nx[31]) begin
          nx <= {nx[30:0], 1'b0};
          e  <= e - 5'd1;
        end
      end
      ntc_pkg::S_LOGM: tab_a <= tab_lo;
      ntc_pkg::S_LOGA: begin
        if (log_sel) begin
          l2 <= l2 - $signed({1'b0, lg});
        end else begin
          l2      <= $signed({1'b0, lg});
          nx      <= 32'(nom_eff);
          e       <= 5'd31;
          log_sel <= 1'b1;
        end
      end
      ntc_pkg::S_LN: ln <= ln_full[21:0];
      ntc_pkg::S_D:  d  <= d_calc;
      ntc_pkg::S_NLOAD: begin
        num <= n_div;
        dvs <= d[38:0];
        rem <= '0;
        cnt <= '0;
      end
      ntc_pkg::S_TEMP: begin
        if (num > 54'(ntc_pkg::TEMP_MAX + ntc_pkg::KELVIN_OFFSET_CENTI)) begin
          temp <= 16'(ntc_pkg::TEMP_MAX);
        end else begin
          temp <= 16'(num - 54'(ntc_pkg::KELVIN_OFFSET_CENTI));
        end
      end
      default: begin
        stat <= stat;
      end
    endcase
  end

  // ports
  assign in_stall            = (state != ntc_pkg::S_IDLE);
  assign out_valid           = (state == ntc_pkg::S_DONE);
  assign filtered_microvolts = fm;
  assign resistance_ohms     = r_out;
  assign temperature_centi_c = temp;
  assign status              = stat;

endmodule

FILE: rtl/ntc_chk.sv
// Port-level checker for ntc_thermistor_temperature, bound to the top level.
// Depends on ntc_pkg.
module ntc_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] filtered_microvolts,
  input logic [31:0]        resistance_ohms,
  input logic signed [15:0] temperature_centi_c,
  input logic               status
);

  // an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(resistance_ohms)
      && $stable(temperature_centi_c) && $stable(filtered_microvolts)
      && $stable(status))
    else $error("result changed while stalled");

  // one item in flight: no input taken while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // out-of-range results saturate the resistance
  a_status_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |->
      (resistance_ohms == 32'd0) || (resistance_ohms == 32'hFFFFFFFF))
    else $error("status set without saturated resistance");

  // low-side fault gives absolute zero
  a_low_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && status && (resistance_ohms == 32'hFFFFFFFF) |->
      temperature_centi_c == 16'(-ntc_pkg::KELVIN_OFFSET_CENTI))
    else $error("low fault temperature wrong");

endmodule

bind ntc_thermistor_temperature ntc_chk u_ntc_chk (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .filtered_microvolts (filtered_microvolts),
  .resistance_ohms     (resistance_ohms),
  .temperature_centi_c (temperature_centi_c),
  .status              (status)
);

FILE: bench/tb_top.sv
// Self-checking bench for ntc_thermistor_temperature: directed table, then random samples
// checked against a fixed-point Beta-equation predictor under three idle patterns.
// Depends on ntc_pkg and the ntc_thermistor_temperature RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_PER_PHASE = 550;

  typedef struct packed {
    logic signed [23:0] fmv;
    logic [31:0]        ohms;
    logic signed [15:0] centi;
    logic               st;
  } reading_t;

  // one row of the directed table: a register write or a sample beat
  typedef struct {
    bit                id_write;
    ntc_pkg::cfg_idx_t idx;
    logic [22:0]       data;
    logic [15:0]       smp;
    bit                typed;
    reading_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] adc_sample = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [23:0] filtered_microvolts;
  logic [31:0] resistance_ohms;
  logic signed [15:0] temperature_centi_c;
  logic status;

  ntc_thermistor_temperature dut (.*);

  always #6 clk = ~clk;

  // predictor state: register copies, filter memory, log2 fraction table
  longint vref_uv, full_scale, offs_uv, weight, series_r, nominal_r, beta_k, tref_ck;
  longint filt_uv;
  longint log2_frac_tab [0:ntc_pkg::LOG_TABLE_SIZE];

  reading_t pending_readings [$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int tx_idle = 14;
  int rx_idle = 88;
  longint cycles = 0;

  function automatic void build_frac_tab();
    logic [63:0] y;
    logic [31:0] r;
    for (int i = 0; i < ntc_pkg::LOG_TABLE_SIZE; i++) begin
      y = (64'(ntc_pkg::LOG_TABLE_SIZE + i) << 30) / ntc_pkg::LOG_TABLE_SIZE;
      r = 0;
      for (int k = 0; k < 17; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r = r | 32'd1;
        end
      end
      log2_frac_tab[i] = longint'((r + 32'd1) >> 1);
    end
    log2_frac_tab[ntc_pkg::LOG_TABLE_SIZE] = 65536;
  endfunction

  // log2(x) in Q16, x >= 1: normalize, then interpolate the table
  function automatic longint log2_q16(input longint x);
    int e;
    longint fr, p, rem, lo, hi;
    int idx;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    fr = (x << (31 - e)) - (64'sd1 << 31);
    p = fr * ntc_pkg::LOG_TABLE_SIZE;
    idx = int'(p >> 31);
    if (idx >= ntc_pkg::LOG_TABLE_SIZE) idx = ntc_pkg::LOG_TABLE_SIZE - 1;
    rem = p & 64'h7FFF_FFFF;
    lo = log2_frac_tab[idx];
    hi = log2_frac_tab[idx + 1];
    return longint'(e) * 65536 + lo + (((hi - lo) * rem) >>> 31);
  endfunction

  function automatic void set_reg(input ntc_pkg::cfg_idx_t idx, input logic [22:0] d);
    case (idx)
      ntc_pkg::CFG_VREF:       vref_uv = d;
      ntc_pkg::CFG_FULL_SCALE: full_scale = d[16:0];
      ntc_pkg::CFG_OFFSET:     offs_uv = longint'($signed(d[19:0]));
      ntc_pkg::CFG_WEIGHT:     weight = d[16:0];
      ntc_pkg::CFG_SERIES:     series_r = d[19:0];
      ntc_pkg::CFG_NOMINAL:    nominal_r = d[19:0];
      ntc_pkg::CFG_BETA:       beta_k = d[13:0];
      ntc_pkg::CFG_TREF:       tref_ck = d[15:0];
      default: ;
    endcase
  endfunction

  // filter update, divider formula and Beta equation for one sample
  function automatic reading_t predict_reading(input logic [15:0] s);
    reading_t rd;
    longint fs, a, v, f, r, r0, l2, lnq, d, n, tck, t;
    fs = (full_scale == 0) ? 1 : full_scale;
    a = (weight > 65536) ? 65536 : weight;
    v = (longint'(s) * vref_uv) / fs - offs_uv;
    f = (a * v + (65536 - a) * filt_uv) >>> 16;
    if (f > 8388607) f = 8388607;
    if (f < -8388608) f = -8388608;
    filt_uv = f;
    rd.fmv = f[23:0];
    rd.st = 1'b0;
    if (f <= 0) begin
      rd.st = 1'b1;
      r = 64'hFFFF_FFFF;
      t = -ntc_pkg::KELVIN_OFFSET_CENTI;
    end else if (f > vref_uv) begin
      rd.st = 1'b1;
      r = 0;
      t = ntc_pkg::TEMP_MAX;
    end else begin
      r = series_r * (vref_uv - f) / f;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      if (r == 0) begin
        t = ntc_pkg::TEMP_MAX;
      end else begin
        r0 = (nominal_r == 0) ? 1 : nominal_r;
        l2 = log2_q16(r) - log2_q16(r0);
        lnq = (l2 * longint'(ntc_pkg::LN2_Q30) + (64'sd1 << 29)) >>> 30;
        d = 100 * beta_k * 65536 + tref_ck * lnq;
        if (d <= 0) begin
          t = ntc_pkg::TEMP_MAX;
        end else begin
          n = 100 * tref_ck * beta_k * 65536;
          tck = (n + (d >>> 1)) / d;
          t = (tck > ntc_pkg::TEMP_MAX + ntc_pkg::KELVIN_OFFSET_CENTI) ?
              ntc_pkg::TEMP_MAX : tck - ntc_pkg::KELVIN_OFFSET_CENTI;
        end
      end
    end
    rd.ohms = r[31:0];
    rd.centi = t[15:0];
    return rd;
  endfunction

  // register write, only once the block has drained
  task automatic write_reg(input ntc_pkg::cfg_idx_t idx, input logic [22:0] d);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_wen <= 1'b0;
    set_reg(idx, d);
  endtask

  // one sample beat, with an optional sender gap in front
  task automatic send_sample(input logic [15:0] s, input bit typed, input reading_t want);
    reading_t rd;
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    do @(posedge clk); while (in_stall);
    rd = predict_reading(s);
    pending_readings.push_back(typed ? want : rd);
    beats_in++;
  endtask

  task automatic send_random(input int count);
    longint fs;
    for (int i = 0; i < count; i++) begin
      fs = (full_scale == 0) ? 1 : full_scale;
      if ($urandom_range(9) < 7)
        send_sample(16'($urandom_range(fs > 65535 ? 65535 : int'(fs))), 1'b0, '0);
      else
        send_sample(16'($urandom_range(65535)), 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stall, check each accepted beat
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < rx_idle);
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result f=%0d r=%0d t=%0d st=%0b", $time,
                 filtered_microvolts, resistance_ohms, temperature_centi_c, status);
        errors++;
      end else begin
        reading_t w;
        w = pending_readings.pop_front();
        if (filtered_microvolts !== w.fmv || resistance_ohms !== w.ohms ||
            temperature_centi_c !== w.centi || status !== w.st) begin
          $display("%0t: mismatch expected f=%0d r=%0d t=%0d st=%0b", $time,
                   w.fmv, w.ohms, w.centi, w.st);
          $display("%0t:          actual   f=%0d r=%0d t=%0d st=%0b", $time,
                   filtered_microvolts, resistance_ohms, temperature_centi_c, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic row_t wr(input ntc_pkg::cfg_idx_t idx, input logic [22:0] d);
    row_t r;
    r = '{1'b1, idx, d, 16'd0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t smp(input logic [15:0] s);
    row_t r;
    r = '{1'b0, ntc_pkg::CFG_VREF, 23'd0, s, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t smp_typed(input logic [15:0] s, input reading_t w);
    row_t r;
    r = '{1'b0, ntc_pkg::CFG_VREF, 23'd0, s, 1'b1, w};
    return r;
  endfunction

  initial begin
    row_t dir_rows [$];
    vref_uv = ntc_pkg::VREF_RST; full_scale = ntc_pkg::FS_RST; offs_uv = 0;
    weight = ntc_pkg::WEIGHT_RST; series_r = ntc_pkg::SERIES_RST;
    nominal_r = ntc_pkg::NOM_RST; beta_k = ntc_pkg::BETA_RST; tref_ck = ntc_pkg::TREF_RST;
    filt_uv = 0;
    build_frac_tab();

    // directed table; typed rows are read straight off the special cases
    dir_rows = '{
      smp_typed(16'd0, '{24'sd0, 32'hFFFF_FFFF, -16'sd27315, 1'b1}),
      smp(16'd65535), smp(16'd4095), smp(16'd1),
      wr(ntc_pkg::CFG_WEIGHT, 23'd65536),
      smp_typed(16'd4096, '{24'sd3300000, 32'd0, 16'sd32767, 1'b0}),
      smp(16'd2048), smp(16'd1), smp(16'd4000),
      wr(ntc_pkg::CFG_VREF, 23'd1000), wr(ntc_pkg::CFG_FULL_SCALE, 23'd1),
      wr(ntc_pkg::CFG_OFFSET, 23'h085EE0),
      smp_typed(16'd1, '{24'sd501000, 32'd0, 16'sd32767, 1'b1}),
      wr(ntc_pkg::CFG_OFFSET, 23'h07FFFF),
      smp_typed(16'd0, '{-24'sd524287, 32'hFFFF_FFFF, -16'sd27315, 1'b1}),
      wr(ntc_pkg::CFG_OFFSET, 23'd0), wr(ntc_pkg::CFG_VREF, 23'd3300000),
      wr(ntc_pkg::CFG_FULL_SCALE, 23'd4096),
      wr(ntc_pkg::CFG_SERIES, 23'd1000000), wr(ntc_pkg::CFG_NOMINAL, 23'd0),
      smp(16'd1), smp(16'd4000), smp(16'd2000),
      wr(ntc_pkg::CFG_BETA, 23'd1), wr(ntc_pkg::CFG_TREF, 23'd50000),
      smp(16'd100), smp(16'd3000),
      wr(ntc_pkg::CFG_WEIGHT, 23'd0), smp(16'd65535), smp(16'hAAAA), smp(16'h5555)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].id_write) begin
        in_valid <= 1'b0;
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    in_valid <= 1'b0;

    // phase 1: reset-value registers, slow receiver
    write_reg(ntc_pkg::CFG_VREF, ntc_pkg::VREF_RST);
    write_reg(ntc_pkg::CFG_FULL_SCALE, 23'(ntc_pkg::FS_RST));
    write_reg(ntc_pkg::CFG_OFFSET, 23'(ntc_pkg::OFFS_RST));
    write_reg(ntc_pkg::CFG_WEIGHT, 23'(ntc_pkg::WEIGHT_RST));
    write_reg(ntc_pkg::CFG_SERIES, 23'(ntc_pkg::SERIES_RST));
    write_reg(ntc_pkg::CFG_NOMINAL, 23'(ntc_pkg::NOM_RST));
    write_reg(ntc_pkg::CFG_BETA, 23'(ntc_pkg::BETA_RST));
    write_reg(ntc_pkg::CFG_TREF, 23'(ntc_pkg::TREF_RST));
    send_random(RAND_PER_PHASE);

    // phase 2: widest ADC range, unity weight, high-end coefficients, slow sender
    tx_idle = 88; rx_idle = 14;
    write_reg(ntc_pkg::CFG_VREF, 23'd5000000); write_reg(ntc_pkg::CFG_FULL_SCALE, 23'd65536);
    write_reg(ntc_pkg::CFG_OFFSET, 23'd1000);  write_reg(ntc_pkg::CFG_WEIGHT, 23'd65536);
    write_reg(ntc_pkg::CFG_SERIES, 23'd1);     write_reg(ntc_pkg::CFG_NOMINAL, 23'd1);
    write_reg(ntc_pkg::CFG_BETA, 23'd10000);   write_reg(ntc_pkg::CFG_TREF, 23'd50000);
    send_random(RAND_PER_PHASE);

    // phase 3: field extremes (zero full scale, weight over one), no idling
    tx_idle = 0; rx_idle = 0;
    write_reg(ntc_pkg::CFG_VREF, 23'h7FFFFF); write_reg(ntc_pkg::CFG_FULL_SCALE, 23'd0);
    write_reg(ntc_pkg::CFG_OFFSET, 23'h07FFFF); write_reg(ntc_pkg::CFG_WEIGHT, 23'h1FFFF);
    write_reg(ntc_pkg::CFG_SERIES, 23'hFFFFF); write_reg(ntc_pkg::CFG_NOMINAL, 23'd0);
    write_reg(ntc_pkg::CFG_BETA, 23'd1);      write_reg(ntc_pkg::CFG_TREF, 23'd1);
    send_random(RAND_PER_PHASE / 2);
    write_reg(ntc_pkg::CFG_FULL_SCALE, 23'd256); write_reg(ntc_pkg::CFG_BETA, 23'h3FFF);
    write_reg(ntc_pkg::CFG_TREF, 23'hFFFF);   write_reg(ntc_pkg::CFG_NOMINAL, 23'hFFFFF);
    write_reg(ntc_pkg::CFG_OFFSET, 23'h080000);
    send_random(RAND_PER_PHASE / 2);

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d samples, checked %0d results over four register settings", beats_in,
             beats_out);
    $display("and three idle patterns; %0d mismatches", errors);
    if (errors == 0 && pending_readings.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: ntc_thermistor_temperature.f
rtl/ntc_pkg.sv
rtl/ntc_thermistor_temperature.sv
rtl/ntc_chk.sv
bench/tb_top.sv
